// File: sv/lf4_pkg.sv
// lf4_pkg: shared constants, types and codes of the four-pole ladder filter
// used by the serial multiplier, the serial divider, the tanh table and the top level
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package lf4_pkg;

	localparam int SAMPLE_BITS = 24;
	localparam int STATE_BITS = 32;
	localparam int TANH_TABLE_DEPTH = 256;

	localparam int FRAC = 20;
	localparam logic [21:0] PI_Q20 = 22'd3294199;
	localparam logic [25:0] G_MAX = 26'h200_0000;
	localparam logic [63:0] MAG_LIMIT = 64'h1000_0000_0000_0000;
	localparam int TANH_SPAN_SHIFT = 22;
	localparam int TANH_BITS = 21;

	// serial multiplier: 36-bit multiplier operand, 4 bits a cycle
	localparam int MUL_BW = 36;
	localparam int MUL_DIG = 4;
	localparam int MUL_STEPS = MUL_BW / MUL_DIG;
	localparam int MUL_PW = 100;

	// serial divider: remainder and quotient widths
	localparam int DIV_RW = 46;
	localparam int DIV_QW = 26;
	localparam int DIV_CW = 5;

	typedef enum logic [1:0] {SH_0, SH_11, SH_20, SH_22} mul_shift_t;

	typedef struct packed {
		logic start;
		logic signed [63:0] a;
		logic [MUL_BW-1:0] b;
		mul_shift_t sh;
	} mul_req_t;

	typedef struct packed {
		logic busy;
		logic done;
		logic signed [63:0] prod;
	} mul_rsp_t;

	typedef struct packed {
		logic start;
		logic [DIV_RW-1:0] rem;
		logic [DIV_QW-1:0] low;
		logic [DIV_CW-1:0] nbits;
		logic [DIV_RW-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic busy;
		logic done;
		logic [DIV_QW-1:0] quo;
	} div_rsp_t;

	typedef enum logic [0:0] {REG_SAMPLE_RATE, REG_RESONANCE} reg_idx_t;

	typedef enum logic [4:0] {
		S_IDLE, S_PIC, S_GDIV, S_GL, S_G2, S_G3, S_G4, S_S0, S_S1, S_S2,
		S_KS, S_KG, S_UDIV, S_TPOS, S_TINT, S_STAGE, S_SCALE, S_OUT
	} seq_state_t;

endpackage
`default_nettype wire

// File: sv/lf4_mul.sv
// lf4_mul: serial signed-by-unsigned multiplier, 4 multiplier bits a cycle,
// with right shift, truncation toward zero and magnitude saturation at 2^60
// depends on lf4_pkg
`timescale 1ns / 1ps
`default_nettype none
module lf4_mul (
	input  logic              clk,
	input  logic              arst_n,
	input  lf4_pkg::mul_req_t req,
	output lf4_pkg::mul_rsp_t rsp
);

	logic run_q, fin_q, done_q;
	logic [3:0] cnt_q;
	logic neg_q;
	logic [63:0] am_q;
	logic [lf4_pkg::MUL_BW-1:0] b_q;
	lf4_pkg::mul_shift_t sh_q;
	logic [lf4_pkg::MUL_PW-1:0] acc_q;
	logic signed [63:0] prod_q;

	logic [67:0] pp;
	logic [lf4_pkg::MUL_PW-1:0] acc_nx, shifted;
	logic [63:0] mag_c, rmag;

	assign mag_c = req.a[63] ? (64'd0 - req.a) : req.a;
	assign pp = 68'(am_q) * 68'(b_q[lf4_pkg::MUL_BW-1 -: lf4_pkg::MUL_DIG]);
	assign acc_nx = {acc_q[lf4_pkg::MUL_PW-5:0], 4'b0} + {32'b0, pp};

	always_comb begin
		case (sh_q)
			lf4_pkg::SH_0:  shifted = acc_q;
			lf4_pkg::SH_11: shifted = acc_q >> 11;
			lf4_pkg::SH_20: shifted = acc_q >> 20;
			lf4_pkg::SH_22: shifted = acc_q >> 22;
			default:        shifted = acc_q;
		endcase
	end

	assign rmag = (shifted > {36'b0, lf4_pkg::MAG_LIMIT}) ? lf4_pkg::MAG_LIMIT : shifted[63:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				run_q <= 1'b1;
				cnt_q <= 4'(lf4_pkg::MUL_STEPS);
			end else if (run_q) begin
				cnt_q <= cnt_q - 4'd1;
				if (cnt_q == 4'd1) begin
					run_q <= 1'b0;
					fin_q <= 1'b1;
				end
			end else if (fin_q) begin
				fin_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			neg_q <= req.a[63];
			am_q  <= mag_c;
			b_q   <= req.b;
			sh_q  <= req.sh;
			acc_q <= '0;
		end else if (run_q) begin
			acc_q <= acc_nx;
			b_q   <= b_q << lf4_pkg::MUL_DIG;
		end
		if (fin_q)
			prod_q <= neg_q ? $signed(64'd0 - rmag) : $signed(rmag);
	end

	assign rsp.busy = run_q | fin_q;
	assign rsp.done = done_q;
	assign rsp.prod = prod_q;

endmodule
`default_nettype wire

// File: sv/lf4_div.sv
// lf4_div: restoring divider, one quotient bit a cycle
// remainder starts below the divisor, low dividend bits shift in msb first
// depends on lf4_pkg
`timescale 1ns / 1ps
`default_nettype none
module lf4_div (
	input  logic              clk,
	input  logic              arst_n,
	input  lf4_pkg::div_req_t req,
	output lf4_pkg::div_rsp_t rsp
);

	logic run_q, done_q;
	logic [lf4_pkg::DIV_CW-1:0] cnt_q;
	logic [lf4_pkg::DIV_RW-1:0] rem_q, den_q, rem2, rem_nx;
	logic [lf4_pkg::DIV_QW-1:0] low_q, quo_q;
	logic ge;

	assign rem2 = {rem_q[lf4_pkg::DIV_RW-2:0], low_q[lf4_pkg::DIV_QW-1]};
	assign ge = rem2 >= den_q;
	assign rem_nx = ge ? (rem2 - den_q) : rem2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				run_q <= 1'b1;
				cnt_q <= req.nbits;
			end else if (run_q) begin
				cnt_q <= cnt_q - lf4_pkg::DIV_CW'(1);
				if (cnt_q == lf4_pkg::DIV_CW'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= req.rem;
			low_q <= req.low;
			den_q <= req.den;
			quo_q <= '0;
		end else if (run_q) begin
			rem_q <= rem_nx;
			low_q <= low_q << 1;
			quo_q <= {quo_q[lf4_pkg::DIV_QW-2:0], ge};
		end
	end

	assign rsp.busy = run_q;
	assign rsp.done = done_q;
	assign rsp.quo  = quo_q;

endmodule
`default_nettype wire

// File: sv/lf4_tanh_rom.sv
// lf4_tanh_rom: tanh table over [0, 4], built at elaboration by the addition
// formula, gives the base point, the step to the next point and the last point
// depends on lf4_pkg
`timescale 1ns / 1ps
`default_nettype none
module lf4_tanh_rom #(
	parameter int DEPTH = 256,
	parameter int IW = $clog2(DEPTH + 1)
) (
	input  logic [IW-1:0]                 idx,
	output logic [lf4_pkg::TANH_BITS-1:0] base,
	output logic [lf4_pkg::TANH_BITS-1:0] diff,
	output logic [lf4_pkg::TANH_BITS-1:0] last
);

	typedef logic [DEPTH:0][lf4_pkg::TANH_BITS-1:0] tab_t;

	// shift-subtract long division, only used while building the table
	function automatic logic [63:0] div_u64(logic [63:0] n, logic [63:0] d);
		logic [63:0] q, r;
		q = '0;
		r = '0;
		for (int b = 63; b >= 0; b--) begin
			r = {r[62:0], n[b]};
			if (r >= d) begin
				r = r - d;
				q[b] = 1'b1;
			end
		end
		return q;
	endfunction

	function automatic tab_t build_tab();
		logic [63:0] x, x2, x3, x5, x7, x9, t, acc;
		tab_t tab;
		x  = div_u64(64'd4 << 30, 64'(DEPTH));
		x2 = (x * x) >> 30;
		x3 = (x2 * x) >> 30;
		x5 = (x3 * x2) >> 30;
		x7 = (x5 * x2) >> 30;
		x9 = (x7 * x2) >> 30;
		t  = x - div_u64(x3, 64'd3) + div_u64(64'd2 * x5, 64'd15)
			- div_u64(64'd17 * x7, 64'd315) + div_u64(64'd62 * x9, 64'd2835);
		acc = '0;
		for (int i = 0; i <= DEPTH; i++) begin
			tab[i] = lf4_pkg::TANH_BITS'((acc + 64'd512) >> 10);
			acc = div_u64((acc + t) << 30, (64'd1 << 30) + ((acc * t) >> 30));
		end
		return tab;
	endfunction

	localparam tab_t TAB = build_tab();

	logic [IW-1:0] i0, i1;

	// clamp so that an unused index never reads past the end
	assign i0 = (idx >= IW'(DEPTH)) ? IW'(DEPTH - 1) : idx;
	assign i1 = i0 + IW'(1);
	assign base = TAB[i0];
	assign diff = TAB[i1] - TAB[i0];
	assign last = TAB[DEPTH];

endmodule
`default_nettype wire

// File: sv/ladder_lowpass_filter_4pole.sv
// Four-pole ladder low-pass filter, zero-delay-feedback form, fixed point.
// Input channel: in_valid/in_ready with sample_in (20 fraction bits) and the
// cutoff in Hz for that sample. Output channel: out_valid/out_ready with
// sample_out, one result per input, in order.
// Configuration: wr_en/wr_index/wr_data write sample_rate_hz (index 0) and
// resonance (index 1) at any edge with wr_en high; write only while idle.
// One item at a time: in_ready is high only when the sequencer is idle.
// The shared serial multiplier (4 bits a cycle) works through 16 products
// in turn; the serial divider works out 26 + 20 + 23 quotient bits for g,
// G and the tanh argument. A saturated g or tanh argument skips its
// division, and a tanh argument of 4.0 or more skips the two table products.
// The finished sample sits in an output register; if the receiver stalls
// with a sample still held, the next result waits in the sequencer until the
// register frees up.
// Reset clears the four integrators, sets sample rate to 48000 and
// resonance to 0, and drops out_valid; no clearing pass is needed.
// depends on lf4_pkg, lf4_mul, lf4_div, lf4_tanh_rom
`timescale 1ns / 1ps
`default_nettype none
module ladder_lowpass_filter_4pole #(
	parameter int SAMPLE_BITS = lf4_pkg::SAMPLE_BITS,
	parameter int STATE_BITS = lf4_pkg::STATE_BITS,
	parameter int TANH_TABLE_DEPTH = lf4_pkg::TANH_TABLE_DEPTH
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [SAMPLE_BITS-1:0] sample_in,
	input  logic [16:0]                   cutoff_hz,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [SAMPLE_BITS-1:0] sample_out,
	input  logic                          wr_en,
	input  logic [0:0]                    wr_index,
	input  logic [17:0]                   wr_data
);

	localparam int TIW = $clog2(TANH_TABLE_DEPTH + 1);
	localparam logic signed [63:0] ST_HI = (64'sd1 <<< (STATE_BITS - 1)) - 64'sd1;
	localparam logic signed [63:0] ST_LO = -ST_HI - 64'sd1;
	localparam logic signed [63:0] SM_HI = (64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1;
	localparam logic signed [63:0] SM_LO = -SM_HI - 64'sd1;

	function automatic logic signed [STATE_BITS-1:0] sat_st(logic signed [63:0] v);
		logic signed [STATE_BITS-1:0] r;
		if (v > ST_HI)
			r = ST_HI[STATE_BITS-1:0];
		else if (v < ST_LO)
			r = ST_LO[STATE_BITS-1:0];
		else
			r = v[STATE_BITS-1:0];
		return r;
	endfunction

	lf4_pkg::seq_state_t state_q, state_nx;
	logic pend_q, out_valid_q;
	logic [17:0] sr_q;
	logic [12:0] res_q;
	logic signed [STATE_BITS-1:0] s_q [4];
	logic [1:0] i_q;

	logic signed [63:0] x_q, stage_in_q;
	logic [16:0] cut_q;
	logic [25:0] g_q;
	logic [19:0] gl_q;
	logic [30:0] g2_q;
	logic [35:0] g3_q;
	logic [40:0] g4_q;
	logic [63:0] acc_q;
	logic [lf4_pkg::DIV_RW-1:0] den_q;
	logic [35:0] tmp_q;
	logic neg_q;
	logic signed [SAMPLE_BITS-1:0] out_q;

	lf4_pkg::mul_req_t mreq;
	lf4_pkg::mul_rsp_t mrsp;
	lf4_pkg::div_req_t dreq;
	lf4_pkg::div_rsp_t drsp;

	logic [lf4_pkg::TANH_BITS-1:0] t_base, t_diff, t_last;
	logic op_done, gsat, usat, tsat, out_load, in_acc;
	logic [63:0] glim, tr;
	logic signed [63:0] vsum, s_cur, num_c;
	logic signed [STATE_BITS-1:0] y_c, s_new;

	lf4_mul u_mul (.clk(clk), .arst_n(arst_n), .req(mreq), .rsp(mrsp));
	lf4_div u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));
	lf4_tanh_rom #(.DEPTH(TANH_TABLE_DEPTH), .IW(TIW)) u_rom (
		.idx(tmp_q[lf4_pkg::TANH_SPAN_SHIFT +: TIW]),
		.base(t_base),
		.diff(t_diff),
		.last(t_last)
	);

	assign in_ready  = (state_q == lf4_pkg::S_IDLE);
	assign in_acc    = in_valid & in_ready;
	assign out_valid = out_valid_q;
	assign sample_out = out_q;
	assign op_done   = mrsp.done | drsp.done;
	assign out_load  = !out_valid_q || out_ready;

	// g saturates when the sample rate is zero or the rounded quotient would pass 32.0
	assign glim = {21'b0, sr_q, 25'b0} + 64'(sr_q);
	assign gsat = (sr_q == 18'd0) || (acc_q >= glim);
	assign usat = acc_q >= {15'b0, den_q, 3'b0};
	assign tsat = tmp_q >= (36'd4 << lf4_pkg::FRAC);
	assign tr   = 64'(t_base) + mrsp.prod;

	assign s_cur = 64'(s_q[i_q]);
	assign vsum  = mrsp.prod + s_cur;
	assign y_c   = sat_st(vsum);
	assign s_new = sat_st(64'(y_c) + mrsp.prod);
	assign num_c = x_q - mrsp.prod;

	// operand select and next state
	always_comb begin
		mreq = '0;
		dreq = '0;
		state_nx = state_q;
		case (state_q)
			lf4_pkg::S_IDLE: begin
				if (in_valid)
					state_nx = lf4_pkg::S_PIC;
			end
			lf4_pkg::S_PIC: begin
				mreq.a  = 64'(cut_q);
				mreq.b  = 36'(lf4_pkg::PI_Q20);
				mreq.sh = lf4_pkg::SH_0;
				mreq.start = !pend_q;
				if (op_done)
					state_nx = lf4_pkg::S_GDIV;
			end
			lf4_pkg::S_GDIV: begin
				dreq.rem   = lf4_pkg::DIV_RW'(acc_q[63:26]);
				dreq.low   = acc_q[25:0];
				dreq.nbits = lf4_pkg::DIV_CW'(26);
				dreq.den   = lf4_pkg::DIV_RW'(sr_q);
				dreq.start = !pend_q && !gsat;
				if (op_done || (!pend_q && gsat))
					state_nx = lf4_pkg::S_GL;
			end
			lf4_pkg::S_GL: begin
				dreq.rem   = lf4_pkg::DIV_RW'(g_q);
				dreq.low   = '0;
				dreq.nbits = lf4_pkg::DIV_CW'(lf4_pkg::FRAC);
				dreq.den   = (lf4_pkg::DIV_RW'(1) << lf4_pkg::FRAC) + lf4_pkg::DIV_RW'(g_q);
				dreq.start = !pend_q;
				if (op_done)
					state_nx = lf4_pkg::S_G2;
			end
			lf4_pkg::S_G2: begin
				mreq.a = 64'(g_q);
				mreq.b = 36'(g_q);
				mreq.sh = lf4_pkg::SH_20;
				mreq.start = !pend_q;
				if (op_done)
					state_nx = lf4_pkg::S_G3;
			end
			lf4_pkg::S_G3: begin
				mreq.a = 64'(g2_q);
				mreq.b = 36'(g_q);
				mreq.sh = lf4_pkg::SH_20;
				mreq.start = !pend_q;
				if (op_done)
					state_nx = lf4_pkg::S_G4;
			end
			lf4_pkg::S_G4: begin
				mreq.a = 64'(g3_q);
				mreq.b = 36'(g_q);
				mreq.sh = lf4_pkg::SH_20;
				mreq.start = !pend_q;
				if (op_done)
					state_nx = lf4_pkg::S_S0;
			end
			lf4_pkg::S_S0: begin
				mreq.a = 64'(s_q[0]);
				mreq.b = g3_q;
				mreq.sh = lf4_pkg::SH_20;
				mreq.start = !pend_q;
				if (op_done)
					state_nx = lf4_pkg::S_S1;
			end
			lf4_pkg::S_S1: begin
				mreq.a = 64'(s_q[1]);
				mreq.b = 36'(g2_q);
				mreq.sh = lf4_pkg::SH_20;
				mreq.start = !pend_q;
				if (op_done)
					state_nx = lf4_pkg::S_S2;
			end
			lf4_pkg::S_S2: begin
				mreq.a = 64'(s_q[2]);
				mreq.b = 36'(g_q);
				mreq.sh = lf4_pkg::SH_20;
				mreq.start = !pend_q;
				if (op_done)
					state_nx = lf4_pkg::S_KS;
			end
			lf4_pkg::S_KS: begin
				mreq.a = $signed(acc_q);
				mreq.b = 36'(res_q);
				mreq.sh = lf4_pkg::SH_11;
				mreq.start = !pend_q;
				if (op_done)
					state_nx = lf4_pkg::S_KG;
			end
			lf4_pkg::S_KG: begin
				mreq.a = 64'(g4_q);
				mreq.b = 36'(res_q);
				mreq.sh = lf4_pkg::SH_11;
				mreq.start = !pend_q;
				if (op_done)
					state_nx = lf4_pkg::S_UDIV;
			end
			lf4_pkg::S_UDIV: begin
				// quotient of mag * 2^20 / den, at most 23 bits once not saturated
				dreq.rem   = acc_q[lf4_pkg::DIV_RW+2:3];
				dreq.low   = {acc_q[2:0], 23'b0};
				dreq.nbits = lf4_pkg::DIV_CW'(23);
				dreq.den   = den_q;
				dreq.start = !pend_q && !usat;
				if (op_done || (!pend_q && usat))
					state_nx = lf4_pkg::S_TPOS;
			end
			lf4_pkg::S_TPOS: begin
				mreq.a = 64'(tmp_q);
				mreq.b = 36'(TANH_TABLE_DEPTH);
				mreq.sh = lf4_pkg::SH_0;
				mreq.start = !pend_q && !tsat;
				if (!pend_q && tsat)
					state_nx = lf4_pkg::S_STAGE;
				else if (op_done)
					state_nx = lf4_pkg::S_TINT;
			end
			lf4_pkg::S_TINT: begin
				mreq.a = 64'(t_diff);
				mreq.b = 36'(tmp_q[lf4_pkg::TANH_SPAN_SHIFT-1:0]);
				mreq.sh = lf4_pkg::SH_22;
				mreq.start = !pend_q;
				if (op_done)
					state_nx = lf4_pkg::S_STAGE;
			end
			lf4_pkg::S_STAGE: begin
				mreq.a = stage_in_q - s_cur;
				mreq.b = 36'(gl_q);
				mreq.sh = lf4_pkg::SH_20;
				mreq.start = !pend_q;
				if (op_done && i_q == 2'd3)
					state_nx = lf4_pkg::S_SCALE;
			end
			lf4_pkg::S_SCALE: begin
				mreq.a = stage_in_q;
				mreq.b = 36'({res_q, 1'b0}) + 36'(2048);
				mreq.sh = lf4_pkg::SH_11;
				mreq.start = !pend_q;
				if (op_done)
					state_nx = lf4_pkg::S_OUT;
			end
			lf4_pkg::S_OUT: begin
				if (out_load)
					state_nx = lf4_pkg::S_IDLE;
			end
			default: state_nx = lf4_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= lf4_pkg::S_IDLE;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
			sr_q        <= 18'd48000;
			res_q       <= '0;
			for (int j = 0; j < 4; j++)
				s_q[j] <= '0;
		end else begin
			state_q <= state_nx;
			if (mreq.start || dreq.start)
				pend_q <= 1'b1;
			else if (op_done)
				pend_q <= 1'b0;
			if (wr_en) begin
				case (lf4_pkg::reg_idx_t'(wr_index))
					lf4_pkg::REG_SAMPLE_RATE: sr_q <= wr_data;
					lf4_pkg::REG_RESONANCE:   res_q <= wr_data[12:0];
					default: ;
				endcase
			end
			// a new sample may replace one that transfers at this edge
			if (state_q == lf4_pkg::S_OUT && out_load)
				out_valid_q <= 1'b1;
			else if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;
			if (state_q == lf4_pkg::S_STAGE && op_done)
				s_q[i_q] <= s_new;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			x_q   <= 64'(sample_in);
			cut_q <= cutoff_hz;
		end
		case (state_q)
			lf4_pkg::S_PIC:
				if (op_done)
					acc_q <= mrsp.prod + 64'(sr_q >> 1);
			lf4_pkg::S_GDIV: begin
				if (!pend_q && gsat)
					g_q <= lf4_pkg::G_MAX;
				else if (op_done)
					g_q <= drsp.quo;
			end
			lf4_pkg::S_GL:
				if (op_done)
					gl_q <= drsp.quo[19:0];
			lf4_pkg::S_G2:
				if (op_done)
					g2_q <= mrsp.prod[30:0];
			lf4_pkg::S_G3:
				if (op_done)
					g3_q <= mrsp.prod[35:0];
			lf4_pkg::S_G4:
				if (op_done)
					g4_q <= mrsp.prod[40:0];
			lf4_pkg::S_S0:
				if (op_done)
					acc_q <= mrsp.prod;
			lf4_pkg::S_S1:
				if (op_done)
					acc_q <= acc_q + mrsp.prod;
			lf4_pkg::S_S2:
				if (op_done)
					acc_q <= acc_q + mrsp.prod + 64'(s_q[3]);
			lf4_pkg::S_KS:
				if (op_done)
					acc_q <= num_c;
			lf4_pkg::S_KG:
				if (op_done) begin
					den_q <= (lf4_pkg::DIV_RW'(1) << lf4_pkg::FRAC)
						+ mrsp.prod[lf4_pkg::DIV_RW-1:0];
					neg_q <= acc_q[63];
					acc_q <= acc_q[63] ? (64'd0 - acc_q) : acc_q;
				end
			lf4_pkg::S_UDIV: begin
				if (!pend_q && usat)
					tmp_q <= 36'd8 << lf4_pkg::FRAC;
				else if (op_done)
					tmp_q <= 36'(drsp.quo);
			end
			lf4_pkg::S_TPOS: begin
				i_q <= 2'd0;
				if (!pend_q && tsat)
					stage_in_q <= neg_q ? -64'(t_last) : 64'(t_last);
				else if (op_done)
					tmp_q <= mrsp.prod[35:0];
			end
			lf4_pkg::S_TINT:
				if (op_done)
					stage_in_q <= neg_q ? $signed(64'd0 - tr) : $signed(tr);
			lf4_pkg::S_STAGE:
				if (op_done) begin
					stage_in_q <= 64'(y_c);
					i_q <= i_q + 2'd1;
				end
			lf4_pkg::S_SCALE:
				if (op_done)
					acc_q <= mrsp.prod;
			lf4_pkg::S_OUT:
				if (out_load) begin
					if ($signed(acc_q) > SM_HI)
						out_q <= SM_HI[SAMPLE_BITS-1:0];
					else if ($signed(acc_q) < SM_LO)
						out_q <= SM_LO[SAMPLE_BITS-1:0];
					else
						out_q <= acc_q[SAMPLE_BITS-1:0];
				end
			default: ;
		endcase
	end

	a_one_unit: assert property (@(posedge clk) disable iff (!arst_n)
		!(mrsp.busy && drsp.busy))
		else $error("multiplier and divider busy together");

	a_done_pending: assert property (@(posedge clk) disable iff (!arst_n)
		op_done |-> pend_q)
		else $error("unit finished with no request pending");

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(mreq.start || dreq.start) |-> (!mrsp.busy && !drsp.busy && !pend_q))
		else $error("request issued while a unit is busy");

	a_in_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> !in_ready)
		else $error("input ready right after a transfer");

endmodule
`default_nettype wire

// File: test/tb_ladder_lowpass_filter_4pole.sv
// Self-checking testbench for the four-pole ladder low-pass filter: a bit-exact
// predictor runs beside the block, every output transfer is checked in order.
// depends on lf4_pkg and ladder_lowpass_filter_4pole
`timescale 1ns / 1ps
module tb_ladder_lowpass_filter_4pole;
	import lf4_pkg::*;

	localparam int SB = 24;
	localparam int SBITS = 32;
	localparam int TDEPTH = 256;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int DRAIN_CYCLES = 300;
	localparam longint unsigned ONE = 64'd1 << FRAC;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic signed [SB-1:0] sample_in = '0;
	logic [16:0] cutoff_hz = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [SB-1:0] sample_out;
	logic wr_en = 1'b0;
	logic [0:0] wr_index = '0;
	logic [17:0] wr_data = '0;

	// predictor state and register copies
	longint integ[4];
	longint unsigned rate_q;
	longint unsigned reso_q;
	longint unsigned tanh_points[0:TDEPTH];

	logic signed [SB-1:0] expected_samples[$];
	int err_count = 0;
	int idle_count = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;

	ladder_lowpass_filter_4pole i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.sample_in(sample_in), .cutoff_hz(cutoff_hz),
		.out_valid(out_valid), .out_ready(out_ready), .sample_out(sample_out),
		.wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data)
	);

	always #10 clk = ~clk;

	// (a*b)>>sh truncated toward zero, magnitude capped at 2^60
	function automatic longint scaled_product(longint a, longint unsigned b, int sh);
		logic [127:0] p;
		logic [63:0] mag;
		mag = (a < 0) ? 64'(-a) : 64'(a);
		p = 128'(mag) * 128'(b);
		p = p >> sh;
		if (p > 128'(MAG_LIMIT))
			p = 128'(MAG_LIMIT);
		return (a < 0) ? -longint'(p[63:0]) : longint'(p[63:0]);
	endfunction

	function automatic longint clamp_bits(longint v, int bits);
		longint hi;
		longint lo;
		hi = (longint'(1) <<< (bits - 1)) - 1;
		lo = -hi - 1;
		if (v > hi) return hi;
		if (v < lo) return lo;
		return v;
	endfunction

	task automatic build_tanh_points();
		longint unsigned x, x2, x3, x5, x7, x9, t, acc;
		x = (64'd4 << 30) / TDEPTH;
		x2 = (x * x) >> 30;
		x3 = (x2 * x) >> 30;
		x5 = (x3 * x2) >> 30;
		x7 = (x5 * x2) >> 30;
		x9 = (x7 * x2) >> 30;
		t = x - x3 / 3 + (2 * x5) / 15 - (17 * x7) / 315 + (62 * x9) / 2835;
		acc = 0;
		for (int i = 0; i <= TDEPTH; i++) begin
			tanh_points[i] = 64'(32'((acc + 512) >> 10));
			acc = ((acc + t) << 30) / ((64'd1 << 30) + ((acc * t) >> 30));
		end
	endtask

	function automatic longint tanh_lookup(longint a);
		longint unsigned mag, pos, idx, frac, r, d;
		mag = (a < 0) ? 64'(-a) : 64'(a);
		if (mag >= (64'd4 << FRAC)) begin
			r = tanh_points[TDEPTH];
		end else begin
			pos = mag * TDEPTH;
			idx = pos >> TANH_SPAN_SHIFT;
			frac = pos & ((64'd1 << TANH_SPAN_SHIFT) - 1);
			if (idx >= TDEPTH) begin
				r = tanh_points[TDEPTH];
			end else begin
				d = 64'(32'(tanh_points[idx + 1] - tanh_points[idx]));
				r = tanh_points[idx] + ((d * frac) >> TANH_SPAN_SHIFT);
			end
		end
		return (a < 0) ? -longint'(r) : longint'(r);
	endfunction

	// one sample through the filter, advancing the integrators
	function automatic logic signed [SB-1:0] filter_predict(logic signed [SB-1:0] smp,
			logic [16:0] fc);
		longint unsigned g, gl, g2, g3, g4, den, mag, q, r, umag;
		longint x, s_sum, num, u, stage_in, v, y, s;
		x = longint'(smp);
		if (rate_q == 0) begin
			g = 64'(G_MAX);
		end else begin
			g = (64'(PI_Q20) * 64'(fc) + rate_q / 2) / rate_q;
			if (g > 64'(G_MAX)) g = 64'(G_MAX);
		end
		gl = (g << FRAC) / (ONE + g);
		g2 = (g * g) >> FRAC;
		g3 = (g2 * g) >> FRAC;
		g4 = (g3 * g) >> FRAC;
		s_sum = scaled_product(integ[0], g3, FRAC) + scaled_product(integ[1], g2, FRAC)
			+ scaled_product(integ[2], g, FRAC) + integ[3];
		num = x - scaled_product(s_sum, reso_q, 11);
		den = ONE + 64'(scaled_product(longint'(g4), reso_q, 11));
		mag = (num < 0) ? 64'(-num) : 64'(num);
		q = mag / den;
		r = mag % den;
		if (q >= 8)
			umag = 64'd8 << FRAC;
		else
			umag = (q << FRAC) + (r << FRAC) / den;
		u = tanh_lookup((num < 0) ? -longint'(umag) : longint'(umag));
		stage_in = u;
		y = 0;
		for (int i = 0; i < 4; i++) begin
			s = integ[i];
			v = scaled_product(stage_in - s, gl, FRAC);
			y = clamp_bits(v + s, SBITS);
			integ[i] = clamp_bits(y + v, SBITS);
			stage_in = y;
		end
		y = clamp_bits(scaled_product(y, 2048 + 2 * reso_q, 11), SB);
		return y[SB-1:0];
	endfunction

	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// output check and watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_count <= 0;
			else
				idle_count <= idle_count + 1;
			if (idle_count >= WATCHDOG_LIMIT) begin
				$display("Test completed with failures");
				$finish;
			end
			if (out_valid && out_ready) begin
				if (expected_samples.size() == 0) begin
					$error("sample_out transfer with nothing expected, actual %0d", sample_out);
					err_count <= err_count + 1;
				end else begin
					if (sample_out !== expected_samples[0]) begin
						$error("sample_out expected %0d actual %0d",
							expected_samples[0], sample_out);
						err_count <= err_count + 1;
					end
					void'(expected_samples.pop_front());
				end
			end
		end
	end

	task automatic send_sample(logic signed [SB-1:0] smp, logic [16:0] fc);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		sample_in <= smp;
		cutoff_hz <= fc;
		do @(posedge clk); while (!in_ready);
		expected_samples.push_back(filter_predict(smp, fc));
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (expected_samples.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(reg_idx_t idx, logic [17:0] val);
		wait_drained();
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= val;
		@(posedge clk);
		wr_en <= 1'b0;
		if (idx == REG_SAMPLE_RATE)
			rate_q = 64'(val);
		else
			reso_q = 64'(val[12:0]);
		@(posedge clk);
	endtask

	task automatic test_reset_defaults();
		send_sample(24'sd0, 17'd1000);
		send_sample(24'sh7FFFFF, 17'd0);
		send_sample(24'sh800000, 17'd96000);
		send_sample(24'sh7FFFFF, 17'd1000);
		send_sample(24'sh7FFFFF, 17'd131071);
		send_sample(24'sh800000, 17'd30000);
		send_sample(24'sd1048576, 17'd5000);
	endtask

	task automatic test_rate_extremes();
		write_reg(REG_SAMPLE_RATE, 18'd0);
		send_sample(24'sd524288, 17'd100);
		send_sample(24'sh800000, 17'd0);
		write_reg(REG_SAMPLE_RATE, 18'd8000);
		send_sample(24'sh7FFFFF, 17'd7000);
		send_sample(24'sh7FFFFF, 17'd20);
		write_reg(REG_SAMPLE_RATE, 18'd192000);
		send_sample(24'sh800000, 17'd96000);
		send_sample(24'sd12345, 17'd50);
		write_reg(REG_SAMPLE_RATE, 18'h3FFFF);
		send_sample(24'sh7FFFFF, 17'd131071);
	endtask

	task automatic test_resonance_extremes();
		write_reg(REG_SAMPLE_RATE, 18'd48000);
		write_reg(REG_RESONANCE, 18'd4096);
		send_sample(24'sh7FFFFF, 17'd2000);
		send_sample(24'sh800000, 17'd2000);
		send_sample(24'sh7FFFFF, 17'd24000);
		write_reg(REG_RESONANCE, 18'd8191);
		send_sample(24'sh7FFFFF, 17'd5000);
		send_sample(24'sh800000, 17'd96000);
		send_sample(24'sd0, 17'd800);
	endtask

	task automatic test_random_phase(int s_idle, int r_stall, logic [17:0] rate,
			logic [17:0] reso, int n_items);
		logic signed [SB-1:0] smp;
		logic [16:0] fc;
		write_reg(REG_SAMPLE_RATE, rate);
		write_reg(REG_RESONANCE, reso);
		send_idle_pct = s_idle;
		recv_stall_pct = r_stall;
		for (int i = 0; i < n_items; i++) begin
			smp = ($urandom_range(1) == 0) ? SB'($urandom)
				: SB'($signed($urandom_range(2097152)) - 1048576);
			case ($urandom_range(3))
				0: fc = 17'($urandom);
				1: fc = 17'($urandom_range(96000));
				default: fc = 17'($urandom_range(8000, 20));
			endcase
			send_sample(smp, fc);
		end
		send_idle_pct = 0;
		recv_stall_pct = 0;
	endtask

	initial begin
		build_tanh_points();
		for (int i = 0; i < 4; i++) integ[i] = 0;
		rate_q = 48000;
		reso_q = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_rate_extremes();
		test_resonance_extremes();
		test_random_phase(0, 0, 18'd48000, 18'd1024, 220);
		test_random_phase(46, 0, 18'd8000, 18'd4096, 220);
		test_random_phase(0, 46, 18'd192000, 18'($urandom_range(8191)), 220);
		test_random_phase(37, 37, 18'($urandom_range(192000, 8000)), 18'd0, 220);
		wait_drained();
		if (err_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

// File: ladder_lowpass_filter_4pole.f
sv/lf4_pkg.sv
sv/lf4_mul.sv
sv/lf4_div.sv
sv/lf4_tanh_rom.sv
sv/ladder_lowpass_filter_4pole.sv
test/tb_ladder_lowpass_filter_4pole.sv
